[src/tcma_pkg.sv]
// Shared constants and types for the three-channel moving-average unit.
package tcma_pkg;

    localparam int unsigned SAMPLE_W    = 12;
    localparam int unsigned OUT_W       = 16;
    localparam int unsigned THR_W       = 12;
    localparam int unsigned SCALE_SHIFT = OUT_W - SAMPLE_W;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(32);

    typedef enum logic {
        OP_SCAN = 1'b0,
        OP_FILL = 1'b1
    } t_op;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [OUT_W-1:0]    t_out;

    // Per-channel result handed from a channel slice to the output register.
    typedef struct packed {
        t_out scaled;
        logic changed;
    } t_chan_res;

endpackage

[src/tcma_ifs.sv]
// Handshake channel interfaces: input word, result word and threshold write.
interface tcma_in_if;
    import tcma_pkg::*;
    logic    valid;
    logic    ready;
    logic    operation;
    t_sample sample_left;
    t_sample sample_middle;
    t_sample sample_right;

    modport source (output valid, operation, sample_left, sample_middle, sample_right,
                    input ready);
    modport sink   (input valid, operation, sample_left, sample_middle, sample_right,
                    output ready);
endinterface

interface tcma_out_if;
    import tcma_pkg::*;
    logic valid;
    logic ready;
    t_out output_left;
    t_out output_middle;
    t_out output_right;
    logic changed;

    modport source (output valid, output_left, output_middle, output_right, changed,
                    input ready);
    modport sink   (input valid, output_left, output_middle, output_right, changed,
                    output ready);
endinterface

interface tcma_cfg_if;
    import tcma_pkg::*;
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[src/tcma_chan.sv]
// One channel slice: sample shift line, running sum, divide by window, change test.
module tcma_chan
    import tcma_pkg::*;
#(
    parameter int unsigned WINDOW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic             i_fill,
    input  t_sample          i_sample,
    input  logic [THR_W-1:0] i_threshold,
    output t_chan_res        o_res
);

    localparam int unsigned SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int unsigned DIV_K  = SUM_W + $clog2(WINDOW);
    localparam int unsigned M_W    = DIV_K + 1;
    localparam int unsigned PROD_W = SUM_W + M_W;
    // Reciprocal rounded up; exact floor for every sum below 2**SUM_W.
    localparam logic [M_W-1:0] DIV_M = M_W'(((1 << DIV_K) + WINDOW - 1) / WINDOW);

    t_sample            r_ring [WINDOW];
    logic [SUM_W-1:0]   r_sum;
    t_sample            r_last;

    logic [SUM_W-1:0]   n_sum;
    logic [PROD_W-1:0]  w_prod;
    t_sample            w_avg;
    t_sample            w_diff;
    t_sample            n_last;

    // Oldest sample sits at the far end of the shift line.
    assign n_sum  = r_sum - SUM_W'(r_ring[WINDOW-1]) + SUM_W'(i_sample);
    assign w_prod = PROD_W'(n_sum) * PROD_W'(DIV_M);
    assign w_avg  = w_prod[DIV_K +: SAMPLE_W];
    assign w_diff = (w_avg >= r_last) ? (w_avg - r_last) : (r_last - w_avg);
    assign n_last = i_fill ? r_last : w_avg;

    assign o_res.scaled  = {n_last, {SCALE_SHIFT{1'b0}}};
    assign o_res.changed = !i_fill && (w_diff > i_threshold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < int'(WINDOW); i++) begin
                r_ring[i] <= '0;
            end
            r_sum  <= '0;
            r_last <= '0;
        end else if (i_advance) begin
            r_ring[0] <= i_sample;
            for (int i = 1; i < int'(WINDOW); i++) begin
                r_ring[i] <= r_ring[i-1];
            end
            r_sum  <= n_sum;
            r_last <= n_last;
        end
    end

endmodule

[src/three_channel_moving_average_unit.sv]
// Top level of the three-channel moving-average unit.
//
//  port    | role        | payload
//  --------+-------------+--------------------------------------------------
//  i_in    | word in     | operation, sample_left/middle/right (12 bit each)
//  o_out   | word out    | output_left/middle/right (16 bit each), changed
//  i_cfg   | reg write   | data: change threshold (12 bit, reset 32)
//
// One input word is taken per cycle unless both stages are full behind a stalled output.
// Its result word is held in the input register, then in the result register on the output.
// The critical path is one channel slice: running-sum update, reciprocal
// multiply and the threshold compare.
// Reset (synchronous, active low) clears the sample lines, sums, stored
// averages and both valid stages, and loads the threshold default.
// A stalled output holds its word; the input register keeps accepting until
// both stages are full.
module three_channel_moving_average_unit
    import tcma_pkg::*;
#(
    parameter int unsigned WINDOW = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcma_in_if.sink     i_in,
    tcma_out_if.source  o_out,
    tcma_cfg_if.sink    i_cfg
);

    localparam int unsigned CHANNELS = 3;

    // Input stage.
    logic             r_in_valid;
    logic             r_op;
    t_sample          r_samples [CHANNELS];

    // Result stage.
    logic             r_out_valid;
    t_out             r_out_scaled [CHANNELS];
    logic             r_out_changed;

    logic [THR_W-1:0] r_threshold;

    logic             w_advance;
    logic             w_fill;
    t_chan_res        w_res [CHANNELS];

    // Move the held word into the result register when that register is free or draining.
    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign i_cfg.ready = 1'b1;
    assign w_fill      = (t_op'(r_op) == OP_FILL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_threshold <= THR_RESET;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_threshold <= i_cfg.data;
            end
        end
    end

    // Payload registers: capture on transfer, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op         <= i_in.operation;
            r_samples[0] <= i_in.sample_left;
            r_samples[1] <= i_in.sample_middle;
            r_samples[2] <= i_in.sample_right;
        end
        if (w_advance) begin
            for (int c = 0; c < int'(CHANNELS); c++) begin
                r_out_scaled[c] <= w_res[c].scaled;
            end
            r_out_changed <= w_res[0].changed || w_res[1].changed || w_res[2].changed;
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        tcma_chan #(
            .WINDOW (WINDOW)
        ) u_chan (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_advance   (w_advance),
            .i_fill      (w_fill),
            .i_sample    (r_samples[c]),
            .i_threshold (r_threshold),
            .o_res       (w_res[c])
        );
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.output_left   = r_out_scaled[0];
    assign o_out.output_middle = r_out_scaled[1];
    assign o_out.output_right  = r_out_scaled[2];
    assign o_out.changed       = r_out_changed;

endmodule

[src/tcma_checker.sv]
// Port-level checks for the three-channel moving-average unit, with its bind.
module tcma_checker
    import tcma_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_out i_out_left,
    input t_out i_out_middle,
    input t_out i_out_right,
    input logic i_out_changed
);

    // Result side is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Input stalls only behind a full, blocked result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled with result side free");

    // Scaled averages always carry zero low bits.
    a_scale_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_left[SCALE_SHIFT-1:0] == '0) &&
                        (i_out_middle[SCALE_SHIFT-1:0] == '0) &&
                        (i_out_right[SCALE_SHIFT-1:0] == '0))
        else $error("scaled average has nonzero low bits");

    // Hold a blocked result word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_left) &&
            $stable(i_out_middle) && $stable(i_out_right) && $stable(i_out_changed))
        else $error("blocked result word changed");

endmodule

bind three_channel_moving_average_unit tcma_checker u_tcma_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_left    (o_out.output_left),
    .i_out_middle  (o_out.output_middle),
    .i_out_right   (o_out.output_right),
    .i_out_changed (o_out.changed)
);

[verif/three_channel_moving_average_unit_tb.sv]
// Self-checking testbench for the three-channel moving-average unit.
`timescale 1ns / 100ps

module three_channel_moving_average_unit_tb;
    import tcma_pkg::*;

    localparam int unsigned WINDOW       = 8;
    localparam int unsigned CHANNELS     = 3;
    localparam int unsigned MAX_IDLE     = 11;
    localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int unsigned SETTLE_CYC   = 6;     // settle margin after draining
    localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no word moving on any channel
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_WORDS  = 285;

    // One sample set going in, one averaged word coming out.
    typedef struct packed {
        t_op     op;
        t_sample left;
        t_sample middle;
        t_sample right;
    } t_sample_set;

    typedef struct packed {
        t_out left;
        t_out middle;
        t_out right;
        logic changed;
    } t_avg_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #2 i_clk = ~i_clk;

    tcma_in_if  in_ch ();
    tcma_out_if out_ch ();
    tcma_cfg_if cfg_ch ();

    three_channel_moving_average_unit #(
        .WINDOW (WINDOW)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Filter mirror: sample lines, running sums, stored averages, threshold.
    // ------------------------------------------------------------------
    t_sample             sample_line [CHANNELS][WINDOW];
    logic [14:0]         running_sum [CHANNELS];
    logic [SAMPLE_W-1:0] prev_avg    [CHANNELS];
    int unsigned         write_slot;
    logic [THR_W-1:0]    change_limit;

    // Stimulus and scoreboard bookkeeping.
    t_sample_set pending_sets [$];
    t_avg_word   expected_avgs [$];
    int unsigned sets_issued    = 0;
    int unsigned sets_accepted  = 0;
    int unsigned scans_taken    = 0;
    int unsigned fills_taken    = 0;
    int unsigned changes_seen   = 0;
    int unsigned error_count    = 0;

    // Handshake flags between the edge processes.
    logic        set_taken    = 1'b0;
    logic        avg_taken    = 1'b0;
    logic        sender_burst = 1'b0;   // no gaps on the input side
    logic        sink_burst   = 1'b0;   // no stalls on the output side
    logic        hold_req     = 1'b0;
    int unsigned send_gap     = 0;
    int unsigned sink_stall   = 0;
    int unsigned hold_left    = 0;

    // Slider positions for the smooth-motion stimulus.
    int slider_pos [CHANNELS];

    // Advance the mirror by one sample set and return the word it must produce.
    function automatic t_avg_word filter_update(t_sample_set s);
        t_sample             smp [CHANNELS];
        logic [SAMPLE_W-1:0] avg;
        logic [SAMPLE_W-1:0] diff;
        t_avg_word           res;
        smp[0] = s.left;
        smp[1] = s.middle;
        smp[2] = s.right;
        res.changed = 1'b0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            running_sum[ch]             = running_sum[ch] - sample_line[ch][write_slot] + smp[ch];
            sample_line[ch][write_slot] = smp[ch];
        end
        write_slot = (write_slot >= WINDOW - 1) ? 0 : write_slot + 1;
        // A fill word only primes the line; averages and flag stay put.
        if (s.op == OP_SCAN) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                avg  = SAMPLE_W'(running_sum[ch] / WINDOW);
                diff = (avg >= prev_avg[ch]) ? avg - prev_avg[ch] : prev_avg[ch] - avg;
                if (diff > change_limit)
                    res.changed = 1'b1;
                prev_avg[ch] = avg;
            end
        end
        res.left   = t_out'(prev_avg[0]) << SCALE_SHIFT;
        res.middle = t_out'(prev_avg[1]) << SCALE_SHIFT;
        res.right  = t_out'(prev_avg[2]) << SCALE_SHIFT;
        return res;
    endfunction

    function automatic int unsigned draw_idle(logic burst);
        return burst ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic t_sample_set make_set(t_op op, int unsigned l, int unsigned m,
                                             int unsigned r);
        t_sample_set s;
        s.op     = op;
        s.left   = t_sample'(l);
        s.middle = t_sample'(m);
        s.right  = t_sample'(r);
        return s;
    endfunction

    // Mostly slider motion: small moves around a position, now and then a jump,
    // full-range noise or a rail value.
    function automatic t_sample make_sample(int ch);
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            slider_pos[ch] = slider_pos[ch] + $urandom_range(0, 96) - 48;
            if (slider_pos[ch] < 0)
                slider_pos[ch] = 0;
            if (slider_pos[ch] > 4095)
                slider_pos[ch] = 4095;
        end else if (kind == 6) begin
            slider_pos[ch] = $urandom_range(0, 4095);
        end else if (kind == 7) begin
            return t_sample'($urandom_range(0, 4095));
        end else if (kind == 8) begin
            return $urandom_range(0, 1) ? t_sample'(4095) : t_sample'(0);
        end
        return t_sample'(slider_pos[ch]);
    endfunction

    task automatic queue_set(t_sample_set s);
        pending_sets.push_back(s);
        sets_issued++;
    endtask

    // Wait until every queued word went in and every averaged word came out,
    // then let the pipeline settle before touching the register.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (sets_accepted != sets_issued || expected_avgs.size() != 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        change_limit = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: take a word at the rising edge, drive at the falling edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : set_accept
        t_sample_set s;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            s = make_set(t_op'(in_ch.operation), in_ch.sample_left, in_ch.sample_middle,
                         in_ch.sample_right);
            expected_avgs.push_back(filter_update(s));
            if (s.op == OP_SCAN)
                scans_taken++;
            else
                fills_taken++;
            sets_accepted++;
            set_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin : set_driver
        logic        offer;
        t_sample_set s;
        if (i_rst_n) begin
            // Hold an offered word until it is taken.
            offer = in_ch.valid && !set_taken;
            if (set_taken) begin
                set_taken = 1'b0;
                send_gap  = draw_idle(sender_burst);
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_sets.size() != 0) begin
                    s = pending_sets.pop_front();
                    in_ch.operation     <= s.op;
                    in_ch.sample_left   <= s.left;
                    in_ch.sample_middle <= s.middle;
                    in_ch.sample_right  <= s.right;
                    offer = 1'b1;
                end
            end
            in_ch.valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls per word, plus one long hold-off on request.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : avg_sink
        logic rdy;
        if (i_rst_n) begin
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (avg_taken) begin
                avg_taken  = 1'b0;
                sink_stall = draw_idle(sink_burst);
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_ch.ready <= rdy;
        end
    end

    // Compare every delivered word against the oldest expectation.
    always @(posedge i_clk) begin : avg_check
        t_avg_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            avg_taken = 1'b1;
            if (expected_avgs.size() == 0) begin
                $error("result word with no expectation pending");
                error_count++;
            end else begin
                want = expected_avgs.pop_front();
                if (want.changed)
                    changes_seen++;
                check_field("output_left", want.left, out_ch.output_left);
                check_field("output_middle", want.middle, out_ch.output_middle);
                check_field("output_right", want.right, out_ch.output_right);
                check_field("changed", want.changed, out_ch.changed);
            end
        end
    end

    // Abort when no word moves on any channel for too long.
    always @(posedge i_clk) begin : watchdog
        int unsigned quiet;
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [THR_W-1:0] limit_plan [PHASES];
        t_op              op;

        // Known levels on every input from time zero.
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.operation      = OP_SCAN;
        in_ch.sample_left    = '0;
        in_ch.sample_middle  = '0;
        in_ch.sample_right   = '0;
        out_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;

        // Mirror starts from the reset state.
        for (int ch = 0; ch < CHANNELS; ch++) begin
            running_sum[ch] = '0;
            prev_avg[ch]    = '0;
            slider_pos[ch]  = 2048;
            for (int k = 0; k < WINDOW; k++)
                sample_line[ch][k] = '0;
        end
        write_slot   = 0;
        change_limit = THR_RESET;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset threshold.
        // Left average lands exactly on the threshold: no change.
        queue_set(make_set(OP_SCAN, 256, 0, 0));
        // Middle one above the threshold: change.
        queue_set(make_set(OP_SCAN, 0, 264, 0));
        queue_set(make_set(OP_SCAN, 0, 0, 4095));
        // Prime the rest of the window at full scale without averaging.
        for (int k = 0; k < 5; k++)
            queue_set(make_set(OP_FILL, 4095, 4095, 4095));
        // Full-scale window: output at its top value.
        for (int k = 0; k < 3; k++)
            queue_set(make_set(OP_SCAN, 4095, 4095, 4095));
        queue_set(make_set(OP_SCAN, 'hAAA, 'h555, 'hFFF));
        queue_set(make_set(OP_SCAN, 'h555, 'hAAA, 'h000));
        for (int k = 0; k < 3; k++)
            queue_set(make_set(OP_SCAN, 0, 0, 0));
        queue_set(make_set(OP_FILL, 0, 0, 0));
        queue_set(make_set(OP_FILL, 4095, 0, 4095));
        for (int k = 0; k < 4; k++)
            queue_set(make_set(OP_SCAN, 0, 0, 0));
        wait_drained();

        // Thresholds: zero, top, random, one, random, back to default.
        limit_plan[0] = '0;
        limit_plan[1] = THR_W'(4095);
        limit_plan[2] = THR_W'($urandom_range(2, 4094));
        limit_plan[3] = THR_W'(1);
        limit_plan[4] = THR_W'($urandom_range(2, 200));
        limit_plan[5] = THR_RESET;

        for (int ph = 0; ph < PHASES; ph++) begin
            write_threshold(limit_plan[ph]);
            // Phase 2: sender streams while the receiver holds off, so the
            // block fills and stalls its input. Phase 4: no idling at all.
            sender_burst = (ph == 2 || ph == 4);
            sink_burst   = (ph == 4);
            if (ph == 2)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                op = ($urandom_range(0, 3) == 0) ? OP_FILL : OP_SCAN;
                queue_set(make_set(op, make_sample(0), make_sample(1), make_sample(2)));
            end
            // Pause the sender until the whole phase has come out.
            wait_drained();
        end

        $display("Ran %0d scan and %0d fill words across %0d threshold settings;",
                 scans_taken, fills_taken, PHASES + 1);
        $display("%0d averaged words carried a change flag, one %0d-cycle output hold-off.",
                 changes_seen, HOLD_CYCLES);
        if (error_count == 0 && expected_avgs.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
src/tcma_pkg.sv
src/tcma_ifs.sv
src/tcma_chan.sv
src/three_channel_moving_average_unit.sv
src/tcma_checker.sv
verif/three_channel_moving_average_unit_tb.sv
